>>> sv/ppfw_pkg.sv
// Shared types and constants for the perspective projection fit window.
`default_nettype none
package ppfw_pkg;

    localparam int CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] REG_CAMERA_X        = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_CAMERA_Y        = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_CAMERA_DISTANCE = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_WINDOW_WIDTH    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_WINDOW_HEIGHT   = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_MUL_X,
        ST_DIV_Y,
        ST_MUL_Y,
        ST_STORE,
        ST_SCALE,
        ST_RD,
        ST_FX,
        ST_DIVO,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

>>> sv/ppfw_ram.sv
// Generic single-port synchronous RAM with registered read.
`default_nettype none
module ppfw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

>>> sv/ppfw_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module ppfw_div #(
    parameter int NW = 64,
    parameter int DW = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic signed [NW-1:0] num,
    input  wire logic signed [DW-1:0] den,
    output logic                      done,
    output logic signed [NW-1:0]      quo,
    output logic signed [NW-1:0]      rem
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg;
    logic [DW:0]   r_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          qneg_reg;
    logic          rneg_reg;
    logic [DW:0]   trial;
    logic [DW:0]   shifted;

    always_comb begin
        shifted = {r_reg[DW-1:0], q_reg[NW-1]};
        trial   = shifted - {1'b0, d_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg    <= num[NW-1] ? NW'(-num) : num;
            d_reg    <= den[DW-1] ? DW'(-den) : den;
            r_reg    <= '0;
            qneg_reg <= num[NW-1] ^ den[DW-1];
            rneg_reg <= num[NW-1];
        end else if (busy_reg) begin
            if (!trial[DW]) begin
                r_reg <= trial;
                q_reg <= {q_reg[NW-2:0], 1'b1};
            end else begin
                r_reg <= shifted;
                q_reg <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign quo = qneg_reg ? NW'(-q_reg) : q_reg;
    assign rem = rneg_reg ? NW'(-r_reg[DW-1:0]) : NW'(r_reg[DW-1:0]);
endmodule
`default_nettype wire

>>> sv/perspective_project_fit_window.sv
// Top level of the perspective projection with bounding-box window fit.
// Usage:
//   s_axis: one vertex per word; tdata = {vertex_z, vertex_y, vertex_x},
//   tlast = final_vertex. Each vertex runs two 64-step divisions on one shared
//   divider; they are skipped when the depth sum is zero or the list is full.
//   Projected points live in two RAMs with registered read; a bounding box
//   is kept in registers.
//   On the final vertex the scale axis is chosen and each stored point is read
//   back and fitted; every fitted point needs two 64-step divisions (x then y).
//   m_axis: tdata = {screen_y, screen_x}, tlast = last_point.
//   A stalled receiver holds the output word; the next point is fitted
//   meanwhile and then waits until the output register frees up.
//   cfg: write cfg_index/cfg_data while idle; registers per index 0..4.
//   Reset (aresetn low, synchronous) restores register defaults, empties the
//   vertex list and clears the box; no clearing pass is needed.
`default_nettype none
module perspective_project_fit_window #(
    parameter int MAX_VERTICES  = 64,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,   // vertex_x, vertex_y, vertex_z
    input  wire logic        s_axis_tlast,   // final_vertex
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // screen_x, screen_y
    output logic             m_axis_tlast,   // last_point
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CNTW = $clog2(MAX_VERTICES + 1);
    localparam logic signed [63:0] SMAX = 64'sh7FFFFFFF;
    localparam logic signed [63:0] SMIN = -64'sh80000000;

    ppfw_pkg::state_t state_reg, state_next;

    logic signed [31:0] cam_x_reg, cam_y_reg, cam_d_reg;
    logic [12:0] win_w_reg, win_h_reg;
    logic signed [31:0] vx_reg, vy_reg, vz_reg;
    logic               last_reg;
    logic signed [31:0] px_reg, py_reg;
    logic signed [31:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic [CNTW-1:0]    count_reg, idx_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] sel_s_reg;
    logic signed [33:0] sel_span_reg;
    logic               flat_reg;
    logic [11:0]        sx_reg, sy_reg;
    logic               axis_y_reg;
    logic [23:0]        odata_reg;
    logic               olast_reg;
    logic               ovalid_reg;

    logic [12:0] w_eff, h_eff;
    assign w_eff = (win_w_reg == 13'd0) ? 13'd1 : ((win_w_reg > 13'd4096) ? 13'd4096 : win_w_reg);
    assign h_eff = (win_h_reg == 13'd0) ? 13'd1 : ((win_h_reg > 13'd4096) ? 13'd4096 : win_h_reg);

    // divider
    logic               div_start, div_done;
    logic               dstart;
    logic signed [63:0] div_num, div_den, div_quo, div_rem;
    ppfw_div #(.NW(64), .DW(64)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dstart), .num(div_num), .den(div_den),
        .done(div_done), .quo(div_quo), .rem(div_rem)
    );

    // memories
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [31:0]   rdx, rdy;
    ppfw_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_ram_x (
        .aclk(aclk), .we(mem_we), .addr(mem_addr), .wdata(px_reg), .rdata(rdx));
    ppfw_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_ram_y (
        .aclk(aclk), .we(mem_we), .addr(mem_addr), .wdata(py_reg), .rdata(rdy));

    logic full;
    assign full = (count_reg == CNTW'(MAX_VERTICES));
    assign mem_we = (state_reg == ppfw_pkg::ST_STORE) && !full;
    assign mem_addr = (state_reg == ppfw_pkg::ST_STORE) ? count_reg[AW-1:0]
                    : (state_reg == ppfw_pkg::ST_RD) ? idx_reg[AW-1:0]
                    : AW'(idx_reg - 1'b1);

    assign s_axis_tready = (state_reg == ppfw_pkg::ST_IDLE);
    assign cfg_ready = (state_reg == ppfw_pkg::ST_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = odata_reg;
    assign m_axis_tlast = olast_reg;

    // projection terms
    logic signed [63:0] den_v, diff_v, q_sat, ptrunc, psum;
    logic signed [31:0] cam_sel;
    logic               on_y;
    assign on_y = (state_reg == ppfw_pkg::ST_DIV_Y) || (state_reg == ppfw_pkg::ST_MUL_Y);
    assign cam_sel = on_y ? cam_y_reg : cam_x_reg;
    assign den_v = 64'(vz_reg) + 64'(cam_d_reg);
    assign diff_v = 64'(on_y ? vy_reg : vx_reg) - 64'(cam_sel);

    always_comb begin
        if (den_v == 64'sd0) begin
            q_sat = (diff_v > 0) ? SMAX : ((diff_v < 0) ? SMIN : 64'sd0);
        end else if (div_quo > SMAX) begin
            q_sat = SMAX;
        end else if (div_quo < SMIN) begin
            q_sat = SMIN;
        end else begin
            q_sat = div_quo;
        end
        ptrunc = prod_reg[63] ? -((-prod_reg) >>> FRACTION_BITS) : (prod_reg >>> FRACTION_BITS);
        psum = 64'(cam_sel) + ptrunc;
        if (psum > SMAX) psum = SMAX;
        else if (psum < SMIN) psum = SMIN;
    end

    // fit terms
    logic signed [33:0] span_x, span_y, sum_x, sum_y;
    logic signed [47:0] cmp_a, cmp_b;
    assign span_x = 34'(max_x_reg) - 34'(min_x_reg);
    assign span_y = 34'(max_y_reg) - 34'(min_y_reg);
    assign sum_x  = 34'(max_x_reg) + 34'(min_x_reg);
    assign sum_y  = 34'(max_y_reg) + 34'(min_y_reg);
    assign cmp_a = 48'($signed({1'b0, h_eff})) * 48'(span_x);
    assign cmp_b = 48'($signed({1'b0, w_eff})) * 48'(span_y);

    logic signed [31:0] pt_cur;
    logic signed [34:0] tval;
    logic signed [63:0] fnum, fden, fq, fv;
    logic [12:0]        fsize;
    logic [11:0]        fclamp;
    assign pt_cur = axis_y_reg ? rdy : rdx;
    assign tval = 35'(pt_cur) * 35'sd2 - 35'(axis_y_reg ? sum_y : sum_x);
    assign fden = 64'sd20 * 64'(sel_span_reg);
    assign fsize = axis_y_reg ? h_eff : w_eff;
    always_comb begin
        fnum = prod_reg;
        fq = div_quo;
        if (div_rem != 64'sd0 && fnum < 0) fq = div_quo - 64'sd1;
        fv = 64'(fsize >> 1) + (flat_reg ? 64'sd0 : fq);
        if (fv < 0) fclamp = 12'd0;
        else if (fv > 64'(fsize) - 64'sd1) fclamp = 12'(fsize - 13'd1);
        else fclamp = fv[11:0];
    end

    always_comb begin
        state_next = state_reg;
        div_start = 1'b0;
        div_num = 64'(diff_v) <<< FRACTION_BITS;
        div_den = den_v;
        case (state_reg)
            ppfw_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = ppfw_pkg::ST_DIV_X;
                end
            end
            ppfw_pkg::ST_DIV_X, ppfw_pkg::ST_DIV_Y: begin
                if (full) state_next = ppfw_pkg::ST_STORE;
                else if (den_v == 64'sd0 || div_done) begin
                    state_next = on_y ? ppfw_pkg::ST_MUL_Y : ppfw_pkg::ST_MUL_X;
                end
            end
            ppfw_pkg::ST_MUL_X: state_next = ppfw_pkg::ST_DIV_Y;
            ppfw_pkg::ST_MUL_Y: state_next = ppfw_pkg::ST_STORE;
            ppfw_pkg::ST_STORE: begin
                state_next = last_reg ? ppfw_pkg::ST_SCALE : ppfw_pkg::ST_IDLE;
            end
            ppfw_pkg::ST_SCALE: begin
                state_next = (count_reg == '0) ? ppfw_pkg::ST_IDLE : ppfw_pkg::ST_RD;
            end
            ppfw_pkg::ST_RD: state_next = ppfw_pkg::ST_FX;
            ppfw_pkg::ST_FX: begin
                div_start = 1'b1;
                div_num = 64'(sel_s_reg) * 64'(tval) * -64'sd7;
                div_den = fden;
                state_next = ppfw_pkg::ST_DIVO;
            end
            ppfw_pkg::ST_DIVO: begin
                if (div_done) begin
                    state_next = axis_y_reg ? ppfw_pkg::ST_OUT : ppfw_pkg::ST_FX;
                end
            end
            ppfw_pkg::ST_OUT: begin
                if (!ovalid_reg || m_axis_tready) begin
                    state_next = (idx_reg == count_reg) ? ppfw_pkg::ST_IDLE : ppfw_pkg::ST_RD;
                end
            end
            default: state_next = ppfw_pkg::ST_IDLE;
        endcase
        if (state_reg == ppfw_pkg::ST_IDLE && s_axis_tvalid) begin
            div_start = 1'b0;
        end
    end

    // kick a projection division on entry of a divide state
    logic div_kick_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_kick_reg <= 1'b0;
        end else begin
            div_kick_reg <= (state_next == ppfw_pkg::ST_DIV_X || state_next == ppfw_pkg::ST_DIV_Y)
                            && (state_next != state_reg);
        end
    end

    assign dstart = div_start || (div_kick_reg && !full && den_v != 64'sd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ppfw_pkg::ST_IDLE;
            cam_x_reg  <= '0;
            cam_y_reg  <= '0;
            cam_d_reg  <= 32'sd65536;
            win_w_reg  <= 13'd640;
            win_h_reg  <= 13'd480;
            count_reg  <= '0;
            idx_reg    <= '0;
            min_x_reg  <= '0;
            max_x_reg  <= '0;
            min_y_reg  <= '0;
            max_y_reg  <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ppfw_pkg::ST_OUT && (!ovalid_reg || m_axis_tready)) begin
                ovalid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                ovalid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    ppfw_pkg::REG_CAMERA_X:        cam_x_reg <= cfg_data;
                    ppfw_pkg::REG_CAMERA_Y:        cam_y_reg <= cfg_data;
                    ppfw_pkg::REG_CAMERA_DISTANCE: cam_d_reg <= cfg_data;
                    ppfw_pkg::REG_WINDOW_WIDTH:    win_w_reg <= cfg_data[12:0];
                    ppfw_pkg::REG_WINDOW_HEIGHT:   win_h_reg <= cfg_data[12:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ppfw_pkg::ST_STORE: begin
                    if (!full) begin
                        count_reg <= count_reg + 1'b1;
                        if (count_reg == '0) begin
                            min_x_reg <= px_reg; max_x_reg <= px_reg;
                            min_y_reg <= py_reg; max_y_reg <= py_reg;
                        end else begin
                            if (px_reg < min_x_reg) min_x_reg <= px_reg;
                            if (px_reg > max_x_reg) max_x_reg <= px_reg;
                            if (py_reg < min_y_reg) min_y_reg <= py_reg;
                            if (py_reg > max_y_reg) max_y_reg <= py_reg;
                        end
                    end
                    idx_reg <= '0;
                end
                ppfw_pkg::ST_SCALE: begin
                    if (count_reg == '0) count_reg <= '0;
                end
                ppfw_pkg::ST_OUT: begin
                    if (!ovalid_reg || m_axis_tready) begin
                        if (idx_reg == count_reg) count_reg <= '0;
                    end
                end
                ppfw_pkg::ST_RD: idx_reg <= idx_reg + 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ppfw_pkg::ST_IDLE) begin
            vx_reg   <= s_axis_tdata[31:0];
            vy_reg   <= s_axis_tdata[63:32];
            vz_reg   <= s_axis_tdata[95:64];
            last_reg <= s_axis_tlast;
        end
        if (state_reg == ppfw_pkg::ST_MUL_X || state_reg == ppfw_pkg::ST_MUL_Y) begin
            if (on_y) py_reg <= psum[31:0];
            else      px_reg <= psum[31:0];
        end
        case (state_reg)
            ppfw_pkg::ST_DIV_X, ppfw_pkg::ST_DIV_Y: begin
                prod_reg <= q_sat * 64'(cam_d_reg);
            end
            ppfw_pkg::ST_SCALE: begin
                flat_reg <= (span_x == 0) && (span_y == 0);
                if ((span_x == 0) || ((span_y != 0) && (cmp_a < cmp_b))) begin
                    sel_s_reg <= 32'($signed({1'b0, h_eff}));
                    sel_span_reg <= (span_y == 0) ? 34'sd1 : span_y;
                end else begin
                    sel_s_reg <= 32'($signed({1'b0, w_eff}));
                    sel_span_reg <= (span_x == 0) ? 34'sd1 : span_x;
                end
            end
            ppfw_pkg::ST_RD: axis_y_reg <= 1'b0;
            ppfw_pkg::ST_FX: prod_reg <= 64'(sel_s_reg) * 64'(tval) * -64'sd7;
            ppfw_pkg::ST_DIVO: begin
                if (div_done) begin
                    if (axis_y_reg) sy_reg <= fclamp;
                    else sx_reg <= fclamp;
                    axis_y_reg <= 1'b1;
                end
            end
            ppfw_pkg::ST_OUT: begin
                if (!ovalid_reg || m_axis_tready) begin
                    odata_reg <= {sy_reg, sx_reg};
                    olast_reg <= (idx_reg == count_reg);
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

>>> verif/fit_window_checker.sv
// Checker for the perspective projection fit window: predicts fitted pixels and compares words.
module fit_window_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          mismatch_count,
    output int          pixels_pending
);

    localparam int MaxVerts = 64;
    localparam int FracBits = 16;

    typedef struct packed {
        logic [11:0] screen_x;
        logic [11:0] screen_y;
        logic        last_point;
    } pixel_t;

    pixel_t            expected_pixels[$];
    logic signed [31:0] cam_x, cam_y, cam_dist;
    logic [12:0]        win_w, win_h;
    logic signed [31:0] proj_x_mem[MaxVerts];
    logic signed [31:0] proj_y_mem[MaxVerts];
    logic signed [31:0] min_x, max_x, min_y, max_y;
    int                 stored;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic signed [31:0] project_axis(longint v, longint c, longint z);
        longint diff, den, q, prod;
        diff = v - c;
        den  = z + longint'(cam_dist);
        if (den == 0)
            q = diff > 0 ? 64'sd2147483647 : (diff < 0 ? -64'sd2147483648 : 0);
        else
            q = clamp32((diff * (64'sd1 <<< FracBits)) / den);
        prod = q * longint'(cam_dist);
        if (prod < 0) prod = -((-prod) >>> FracBits);
        else prod = prod >>> FracBits;
        return 32'(clamp32(c + prod));
    endfunction

    function automatic longint window_size(logic [12:0] r);
        if (r == 0) return 1;
        if (r > 4096) return 4096;
        return longint'(r);
    endfunction

    function automatic logic [11:0] place(longint p, longint sum, longint size,
                                          longint s_sel, longint span_sel, bit flat);
        longint v, n, d, q;
        v = size / 2;
        if (!flat) begin
            n = -7 * s_sel * (2 * p - sum);
            d = 20 * span_sel;
            q = n / d;
            if ((n % d) != 0 && n < 0) q = q - 1;
            v = v + q;
        end
        if (v < 0) v = 0;
        if (v > size - 1) v = size - 1;
        return v[11:0];
    endfunction

    task automatic project_vertex(logic [95:0] word, logic final_vertex);
        logic signed [31:0] px, py;
        longint w, h, span_x, span_y, sum_x, sum_y, s_sel, span_sel;
        bit flat;
        pixel_t pix;
        if (stored < MaxVerts) begin
            px = project_axis(longint'($signed(word[31:0])), longint'(cam_x),
                              longint'($signed(word[95:64])));
            py = project_axis(longint'($signed(word[63:32])), longint'(cam_y),
                              longint'($signed(word[95:64])));
            proj_x_mem[stored] = px;
            proj_y_mem[stored] = py;
            if (stored == 0) begin
                min_x = px; max_x = px; min_y = py; max_y = py;
            end else begin
                if (px < min_x) min_x = px;
                if (px > max_x) max_x = px;
                if (py < min_y) min_y = py;
                if (py > max_y) max_y = py;
            end
            stored++;
        end
        if (!final_vertex) return;
        w = window_size(win_w);
        h = window_size(win_h);
        span_x = longint'(max_x) - longint'(min_x);
        span_y = longint'(max_y) - longint'(min_y);
        sum_x  = longint'(max_x) + longint'(min_x);
        sum_y  = longint'(max_y) + longint'(min_y);
        flat = 0;
        if (span_x == 0 && span_y == 0) begin
            flat = 1; s_sel = 1; span_sel = 1;
        end else if (span_x == 0) begin
            s_sel = h; span_sel = span_y;
        end else if (span_y == 0) begin
            s_sel = w; span_sel = span_x;
        end else if (h * span_x < w * span_y) begin
            s_sel = h; span_sel = span_y;
        end else begin
            s_sel = w; span_sel = span_x;
        end
        for (int i = 0; i < stored; i++) begin
            pix.screen_x   = place(longint'(proj_x_mem[i]), sum_x, w, s_sel, span_sel, flat);
            pix.screen_y   = place(longint'(proj_y_mem[i]), sum_y, h, s_sel, span_sel, flat);
            pix.last_point = (i + 1 == stored);
            expected_pixels.push_back(pix);
        end
        stored = 0;
    endtask

    always @(posedge aclk) begin
        pixel_t want, got;
        if (!aresetn) begin
            cam_x = 0;
            cam_y = 0;
            cam_dist = 32'sd65536;
            win_w = 13'd640;
            win_h = 13'd480;
            min_x = 0; max_x = 0; min_y = 0; max_y = 0;
            stored = 0;
            expected_pixels.delete();
            mismatch_count <= 0;
            pixels_pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    ppfw_pkg::REG_CAMERA_X:        cam_x = cfg_data;
                    ppfw_pkg::REG_CAMERA_Y:        cam_y = cfg_data;
                    ppfw_pkg::REG_CAMERA_DISTANCE: cam_dist = cfg_data;
                    ppfw_pkg::REG_WINDOW_WIDTH:    win_w = cfg_data[12:0];
                    ppfw_pkg::REG_WINDOW_HEIGHT:   win_h = cfg_data[12:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                project_vertex(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[11:0], m_axis_tdata[23:12], m_axis_tlast};
                if (expected_pixels.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected word x=%0d y=%0d last=%0d",
                                 got.screen_x, got.screen_y, got.last_point);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = expected_pixels.pop_front();
                    if (want != got) begin
                        if (mismatch_count < 10)
                            $display("mismatch: expected x=%0d y=%0d last=%0d, got x=%0d y=%0d last=%0d",
                                     want.screen_x, want.screen_y, want.last_point,
                                     got.screen_x, got.screen_y, got.last_point);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            pixels_pending <= expected_pixels.size();
        end
    end

endmodule

>>> verif/testbench.sv
// Top of the fit window testbench: clock, reset, vertex and register stimulus, verdict.
module testbench;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int          mismatch_count, pixels_pending;
    int          send_idle_pct = 24, recv_idle_pct = 86;
    int          vertices_sent = 0, stall_cycles = 0;
    logic signed [31:0] cur_dist = 32'sd65536;
    bit          overflow_done = 0;

    always #6 aclk = ~aclk;

    perspective_project_fit_window i_dut (.*);

    fit_window_checker i_checker (.*);

    always @(posedge aclk) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready) || !aresetn)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 40000) begin
            $display("[perspective_project_fit_window] ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        if (idx == ppfw_pkg::REG_CAMERA_DISTANCE) cur_dist = value;
    endtask

    task automatic send_vertex(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz, logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {vz, vy, vx};
        s_axis_tlast  <= fin;
        do @(posedge aclk); while (!s_axis_tready);
        vertices_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge aclk);
        while (pixels_pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    function automatic logic [31:0] coord();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return 32'h7FFFFFFF;
            2:       return 32'h80000000;
            default: return 32'($urandom_range(1 << 21) - (1 << 20));
        endcase
    endfunction

    function automatic logic [31:0] depth();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return -cur_dist;
            default: return 32'($urandom_range(1 << 21) - (1 << 18));
        endcase
    endfunction

    task automatic random_setup();
        logic [31:0] sizes[5] = '{32'd1, 32'd4096, 32'd0, 32'd8191, 32'd640};
        logic [31:0] dists[6] = '{32'd65536, 32'd1, 32'hFFFF0000, 32'h7FFFFFFF,
                                  32'h80000000, 32'd0};
        write_reg(ppfw_pkg::REG_CAMERA_X, $urandom_range(3) == 0 ? $urandom
                                : 32'($urandom_range(1 << 18) - (1 << 17)));
        write_reg(ppfw_pkg::REG_CAMERA_Y, $urandom_range(3) == 0 ? $urandom
                                : 32'($urandom_range(1 << 18) - (1 << 17)));
        write_reg(ppfw_pkg::REG_CAMERA_DISTANCE, $urandom_range(2) == 0
                  ? dists[$urandom_range(5)] : 32'($urandom_range(1 << 20)));
        write_reg(ppfw_pkg::REG_WINDOW_WIDTH, $urandom_range(1) ? sizes[$urandom_range(4)]
                                    : 32'($urandom_range(4096, 1)));
        write_reg(ppfw_pkg::REG_WINDOW_HEIGHT, $urandom_range(1) ? sizes[$urandom_range(4)]
                                     : 32'($urandom_range(4096, 1)));
    endtask

    initial begin
        int count;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        write_reg(ppfw_pkg::REG_CAMERA_X, 32'd0);
        write_reg(ppfw_pkg::REG_CAMERA_Y, 32'd0);
        write_reg(ppfw_pkg::REG_CAMERA_DISTANCE, 32'd65536);
        write_reg(ppfw_pkg::REG_WINDOW_WIDTH, 32'd640);
        write_reg(ppfw_pkg::REG_WINDOW_HEIGHT, 32'd480);

        send_vertex(32'h7FFFFFFF, 32'h80000000, 32'd0, 1);
        send_vertex(32'h00010000, 32'hFFFF0000, 32'hFFFF0000, 0);
        send_vertex(32'hFFFF0000, 32'h00010000, 32'hFFFF0000, 0);
        send_vertex(32'd0, 32'd0, 32'hFFFF0000, 0);
        send_vertex(32'h00020000, 32'h00030000, 32'h00010000, 1);
        send_vertex(32'h00050000, 32'h00010000, 32'd0, 0);
        send_vertex(32'h00050000, 32'hFFF00000, 32'd0, 1);
        send_vertex(32'h00010000, 32'h00040000, 32'd0, 0);
        send_vertex(32'hFFF80000, 32'h00040000, 32'd0, 1);
        send_vertex(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0);
        send_vertex(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 0);
        send_vertex(32'hFFFFFFFF, 32'h00000001, 32'h00008000, 0);
        send_vertex(32'h00123456, 32'hFFEDCBA9, 32'h00200000, 1);
        drain();

        write_reg(ppfw_pkg::REG_WINDOW_WIDTH, 32'd4096);
        write_reg(ppfw_pkg::REG_WINDOW_HEIGHT, 32'd1);
        send_vertex(32'h00010000, 32'h00020000, 32'd0, 0);
        send_vertex(32'hFFFF0000, 32'h00050000, 32'd0, 1);
        drain();

        while (vertices_sent < 200) begin
            if (vertices_sent >= 80 && vertices_sent < 150) begin
                send_idle_pct = 86; recv_idle_pct = 24;
            end else if (vertices_sent >= 150) begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            if ($urandom_range(2) == 0) random_setup();
            if (!overflow_done && vertices_sent > 100) begin
                count = 67;
                overflow_done = 1;
            end else begin
                count = $urandom_range(6) == 0 ? $urandom_range(20, 1) : $urandom_range(6, 1);
            end
            for (int i = 0; i < count; i++)
                send_vertex(coord(), coord(), depth(), i == count - 1);
            drain();
        end

        if (mismatch_count == 0 && pixels_pending == 0)
            $display("[perspective_project_fit_window] OK");
        else
            $display("[perspective_project_fit_window] ERROR");
        $finish;
    end

endmodule
